[rtl/spi_eeprom_access_sequencer_macros.svh]
// Assertion macros shared by the SPI EEPROM sequencer RTL.
`ifndef SPI_EEPROM_ACCESS_SEQUENCER_MACROS_SVH
`define SPI_EEPROM_ACCESS_SEQUENCER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SEAS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked from one clock edge to the next.
`define SEAS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/seas_pkg.sv]
// Types, codes and helpers for the SPI EEPROM access sequencer.
package seas_pkg;

    // Input operation codes
    typedef enum logic [2:0] {
        OP_START_READ  = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_WRITE_DATA  = 3'd2,
        OP_SPI_REPLY   = 3'd3,
        OP_DELAY_TICK  = 3'd4
    } op_t;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_SEL_ON  = 3'd0,
        ACT_SEL_OFF = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_NEED    = 3'd3,
        ACT_READ    = 3'd4,
        ACT_WAIT    = 3'd5,
        ACT_DONE    = 3'd6
    } act_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_POLL_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_ATTEMPT_LIMIT = 3'd1;
    localparam logic [2:0] CFG_READ_OPCODE   = 3'd2;
    localparam logic [2:0] CFG_WRITE_OPCODE  = 3'd3;
    localparam logic [2:0] CFG_ENABLE_OPCODE = 3'd4;
    localparam logic [2:0] CFG_STATUS_OPCODE = 3'd5;
    localparam logic [2:0] CFG_BUSY_MASK     = 3'd6;
    localparam logic [2:0] CFG_ENABLED_MASK  = 3'd7;

    // Sequencer phases, one-hot
    typedef enum logic [12:0] {
        PH_IDLE      = 13'b0000000000001,
        PH_POLL_CMD  = 13'b0000000000010,
        PH_POLL_DATA = 13'b0000000000100,
        PH_WAIT      = 13'b0000000001000,
        PH_WREN_CMD  = 13'b0000000010000,
        PH_WEL_CMD   = 13'b0000000100000,
        PH_WEL_DATA  = 13'b0000001000000,
        PH_CMD       = 13'b0000010000000,
        PH_ADDR_HI   = 13'b0000100000000,
        PH_ADDR_LO   = 13'b0001000000000,
        PH_RD_DATA   = 13'b0010000000000,
        PH_NEED_DATA = 13'b0100000000000,
        PH_WR_DATA   = 13'b1000000000000
    } phase_t;

    // One result beat
    typedef struct packed {
        act_t        act;
        logic [7:0]  byte_value;
        logic [15:0] done_count;
        logic        last;
    } res_t;

    localparam int MAX_RES = 4;

    function automatic res_t mk_res(act_t act, logic [7:0] bval, logic [15:0] cnt);
        res_t r;
        r.act        = act;
        r.byte_value = bval;
        r.done_count = cnt;
        r.last       = 1'b0;
        return r;
    endfunction

    // Status bit test; an empty mask tests the whole byte
    function automatic logic flags_set(logic [7:0] st, logic [7:0] mask);
        return (mask != 8'd0) ? ((st & mask) != 8'd0) : (st != 8'd0);
    endfunction

endpackage

[rtl/spi_eeprom_access_sequencer.sv]
// Timing: an accepted beat is registered in the input register, then its results load the
//   result buffer once that buffer is free; the first result beat is valid from the result buffer.
// Throughput: one input beat per clock while each item gives at most one result and the
//   output takes it; an item giving several results holds the input side while its result buffer drains.
// Reset: rst_n is asynchronous, active low; the sequencer returns to idle, the result
//   buffer empties and the configuration registers take their default values.
`include "spi_eeprom_access_sequencer_macros.svh"

module spi_eeprom_access_sequencer
    import seas_pkg::*;
#(
    parameter int MEM_SIZE  = 65536,   // memory size in bytes, 256..65536
    parameter int PAGE_SIZE = 64       // write page size, power of two, 8..256
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // Event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address, count, data_byte, rx_byte
    input  logic [2:0]  s_axis_tuser,   // operation

    // Bus action stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // byte_value[7:0], done_count[23:8]
    output logic [2:0]  m_axis_tuser,   // action
    output logic        m_axis_tlast    // last
);

    localparam int PAGE_BITS = $clog2(PAGE_SIZE);
    localparam logic [16:0] MEM_END = 17'(MEM_SIZE);

    // Configuration registers
    logic [7:0] poll_limit_reg;
    logic [2:0] attempt_limit_reg;
    logic [7:0] read_opcode_reg;
    logic [7:0] write_opcode_reg;
    logic [7:0] enable_opcode_reg;
    logic [7:0] status_opcode_reg;
    logic [7:0] busy_mask_reg;
    logic [7:0] enabled_mask_reg;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic        is_write_reg, is_write_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] bytes_done_reg, bytes_done_next;
    logic [2:0]  attempts_left_reg, attempts_left_next;
    logic [7:0]  polls_left_reg, polls_left_next;

    // Input register
    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic [47:0] in_data_reg;

    // Result buffer
    res_t        res_buf_reg [MAX_RES];
    res_t        res_arr     [MAX_RES];
    logic [2:0]  res_n_reg;
    logic [2:0]  res_idx_reg;
    logic [2:0]  res_k;

    logic        out_beat;
    logic        buf_free;
    logic        process;

    op_t         in_op;
    logic [15:0] in_addr;
    logic [15:0] in_cnt;
    logic [7:0]  in_db;
    logic [7:0]  in_rx;

    assign in_op   = op_t'(in_op_reg);
    assign in_addr = in_data_reg[15:0];
    assign in_cnt  = in_data_reg[31:16];
    assign in_db   = in_data_reg[39:32];
    assign in_rx   = in_data_reg[47:40];

    // Configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg    <= 8'd255;
            attempt_limit_reg <= 3'd3;
            read_opcode_reg   <= 8'h03;
            write_opcode_reg  <= 8'h02;
            enable_opcode_reg <= 8'h06;
            status_opcode_reg <= 8'h05;
            busy_mask_reg     <= 8'h01;
            enabled_mask_reg  <= 8'h02;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLL_LIMIT:    poll_limit_reg    <= cfg_data;
                CFG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data[2:0];
                CFG_READ_OPCODE:   read_opcode_reg   <= cfg_data;
                CFG_WRITE_OPCODE:  write_opcode_reg  <= cfg_data;
                CFG_ENABLE_OPCODE: enable_opcode_reg <= cfg_data;
                CFG_STATUS_OPCODE: status_opcode_reg <= cfg_data;
                CFG_BUSY_MASK:     busy_mask_reg     <= cfg_data;
                CFG_ENABLED_MASK:  enabled_mask_reg  <= cfg_data;
                default:           poll_limit_reg    <= poll_limit_reg;
            endcase
        end
    end

    // Handshake and buffer control
    assign m_axis_tvalid = (res_idx_reg != res_n_reg);
    assign out_beat      = m_axis_tvalid && m_axis_tready;
    assign buf_free      = (res_idx_reg == res_n_reg)
                        || (out_beat && (res_idx_reg == 3'(res_n_reg - 3'd1)));
    assign process       = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || process;

    assign m_axis_tdata  = {res_buf_reg[res_idx_reg[1:0]].done_count,
                            res_buf_reg[res_idx_reg[1:0]].byte_value};
    assign m_axis_tuser  = res_buf_reg[res_idx_reg[1:0]].act;
    assign m_axis_tlast  = res_buf_reg[res_idx_reg[1:0]].last;

    // Event step: next state and the result beats of one event
    always_comb
    begin
        logic [15:0] addr_mv;
        logic [15:0] left_mv;
        logic [15:0] done_mv;

        phase_next         = phase_reg;
        is_write_next      = is_write_reg;
        cur_addr_next      = cur_addr_reg;
        bytes_left_next    = bytes_left_reg;
        bytes_done_next    = bytes_done_reg;
        attempts_left_next = attempts_left_reg;
        polls_left_next    = polls_left_reg;
        res_k              = 3'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_arr[i] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
        end

        addr_mv = cur_addr_reg + 16'd1;
        left_mv = bytes_left_reg - 16'd1;
        done_mv = bytes_done_reg + 16'd1;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_op == OP_START_READ || in_op == OP_START_WRITE)
                begin
                    is_write_next      = (in_op == OP_START_WRITE);
                    cur_addr_next      = in_addr;
                    bytes_left_next    = in_cnt;
                    bytes_done_next    = 16'd0;
                    attempts_left_next = (in_op == OP_START_WRITE) ? attempt_limit_reg : 3'd0;
                    if (({1'b0, in_addr} + {1'b0, in_cnt}) > MEM_END
                        || (in_op == OP_START_WRITE && attempt_limit_reg == 3'd0))
                    begin
                        res_arr[0] = mk_res(ACT_DONE, 8'd0, 16'd0);
                        res_k      = 3'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        polls_left_next = poll_limit_reg;
                        res_arr[0] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                        res_arr[1] = mk_res(ACT_SEND, status_opcode_reg, 16'd0);
                        res_k      = 3'd2;
                        phase_next = PH_POLL_CMD;
                    end
                end
            end

            PH_NEED_DATA:
            begin
                if (in_op == OP_WRITE_DATA)
                begin
                    res_arr[0] = mk_res(ACT_SEND, in_db, 16'd0);
                    res_k      = 3'd1;
                    phase_next = PH_WR_DATA;
                end
            end

            PH_WAIT:
            begin
                if (in_op == OP_DELAY_TICK)
                begin
                    res_arr[0] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                    res_arr[1] = mk_res(ACT_SEND, status_opcode_reg, 16'd0);
                    res_k      = 3'd2;
                    phase_next = PH_POLL_CMD;
                end
            end

            PH_POLL_CMD:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEND, 8'd0, 16'd0);
                    res_k      = 3'd1;
                    phase_next = PH_POLL_DATA;
                end
            end

            PH_POLL_DATA:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                    if (flags_set(in_rx, busy_mask_reg))
                    begin
                        if (polls_left_reg <= 8'd1)
                        begin
                            polls_left_next = 8'd0;
                            // out of polls: a read ends; a write retries until its attempts run out
                            if (is_write_reg && attempts_left_reg > 3'd1)
                            begin
                                attempts_left_next = attempts_left_reg - 3'd1;
                                polls_left_next    = poll_limit_reg;
                                res_arr[1] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                                res_arr[2] = mk_res(ACT_SEND, status_opcode_reg, 16'd0);
                                res_k      = 3'd3;
                                phase_next = PH_POLL_CMD;
                            end
                            else
                            begin
                                if (is_write_reg)
                                begin
                                    attempts_left_next = 3'd0;
                                end
                                res_arr[1] = mk_res(ACT_DONE, 8'd0, bytes_done_reg);
                                res_k      = 3'd2;
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            polls_left_next = polls_left_reg - 8'd1;
                            res_arr[1] = mk_res(ACT_WAIT, 8'd0, 16'd0);
                            res_k      = 3'd2;
                            phase_next = PH_WAIT;
                        end
                    end
                    else
                    begin
                        res_arr[1] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                        res_arr[2] = mk_res(ACT_SEND,
                                            is_write_reg ? enable_opcode_reg : read_opcode_reg,
                                            16'd0);
                        res_k      = 3'd3;
                        phase_next = is_write_reg ? PH_WREN_CMD : PH_CMD;
                    end
                end
            end

            PH_WREN_CMD:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                    res_arr[1] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                    res_arr[2] = mk_res(ACT_SEND, status_opcode_reg, 16'd0);
                    res_k      = 3'd3;
                    phase_next = PH_WEL_CMD;
                end
            end

            PH_WEL_CMD:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEND, 8'd0, 16'd0);
                    res_k      = 3'd1;
                    phase_next = PH_WEL_DATA;
                end
            end

            PH_WEL_DATA:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                    if (flags_set(in_rx, enabled_mask_reg))
                    begin
                        res_arr[1] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                        res_arr[2] = mk_res(ACT_SEND, write_opcode_reg, 16'd0);
                        res_k      = 3'd3;
                        phase_next = PH_CMD;
                    end
                    else if (attempts_left_reg > 3'd1)
                    begin
                        // enable latch clear: retry from the status poll
                        attempts_left_next = attempts_left_reg - 3'd1;
                        polls_left_next    = poll_limit_reg;
                        res_arr[1] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                        res_arr[2] = mk_res(ACT_SEND, status_opcode_reg, 16'd0);
                        res_k      = 3'd3;
                        phase_next = PH_POLL_CMD;
                    end
                    else
                    begin
                        attempts_left_next = 3'd0;
                        res_arr[1] = mk_res(ACT_DONE, 8'd0, bytes_done_reg);
                        res_k      = 3'd2;
                        phase_next = PH_IDLE;
                    end
                end
            end

            PH_CMD:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEND, cur_addr_reg[15:8], 16'd0);
                    res_k      = 3'd1;
                    phase_next = PH_ADDR_HI;
                end
            end

            PH_ADDR_HI:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    res_arr[0] = mk_res(ACT_SEND, cur_addr_reg[7:0], 16'd0);
                    res_k      = 3'd1;
                    phase_next = PH_ADDR_LO;
                end
            end

            PH_ADDR_LO:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    if (bytes_left_reg == 16'd0)
                    begin
                        res_arr[0] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                        res_arr[1] = mk_res(ACT_DONE, 8'd0, bytes_done_reg);
                        res_k      = 3'd2;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res_arr[0] = mk_res(is_write_reg ? ACT_NEED : ACT_SEND, 8'd0, 16'd0);
                        res_k      = 3'd1;
                        phase_next = is_write_reg ? PH_NEED_DATA : PH_RD_DATA;
                    end
                end
            end

            PH_RD_DATA:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    cur_addr_next   = addr_mv;
                    bytes_left_next = left_mv;
                    bytes_done_next = done_mv;
                    res_arr[0] = mk_res(ACT_READ, in_rx, 16'd0);
                    if (left_mv == 16'd0)
                    begin
                        res_arr[1] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                        res_arr[2] = mk_res(ACT_DONE, 8'd0, done_mv);
                        res_k      = 3'd3;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res_arr[1] = mk_res(ACT_SEND, 8'd0, 16'd0);
                        res_k      = 3'd2;
                        phase_next = PH_RD_DATA;
                    end
                end
            end

            PH_WR_DATA:
            begin
                if (in_op == OP_SPI_REPLY)
                begin
                    cur_addr_next   = addr_mv;
                    bytes_left_next = left_mv;
                    bytes_done_next = done_mv;
                    if (left_mv == 16'd0)
                    begin
                        res_arr[0] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                        res_arr[1] = mk_res(ACT_DONE, 8'd0, done_mv);
                        res_k      = 3'd2;
                        phase_next = PH_IDLE;
                    end
                    else if (addr_mv[PAGE_BITS-1:0] == '0)
                    begin
                        // page boundary: close the burst and poll again
                        attempts_left_next = attempt_limit_reg;
                        polls_left_next    = poll_limit_reg;
                        res_arr[0] = mk_res(ACT_SEL_OFF, 8'd0, 16'd0);
                        res_arr[1] = mk_res(ACT_SEL_ON, 8'd0, 16'd0);
                        res_arr[2] = mk_res(ACT_SEND, status_opcode_reg, 16'd0);
                        res_k      = 3'd3;
                        phase_next = PH_POLL_CMD;
                    end
                    else
                    begin
                        res_arr[0] = mk_res(ACT_NEED, 8'd0, 16'd0);
                        res_k      = 3'd1;
                        phase_next = PH_NEED_DATA;
                    end
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // mark the final beat of this event
        if (res_k != 3'd0)
        begin
            res_arr[2'(res_k - 3'd1)].last = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            res_n_reg         <= 3'd0;
            res_idx_reg       <= 3'd0;
            phase_reg         <= PH_IDLE;
            is_write_reg      <= 1'b0;
            cur_addr_reg      <= 16'd0;
            bytes_left_reg    <= 16'd0;
            bytes_done_reg    <= 16'd0;
            attempts_left_reg <= 3'd0;
            polls_left_reg    <= 8'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end

            if (process)
            begin
                res_n_reg         <= res_k;
                res_idx_reg       <= 3'd0;
                phase_reg         <= phase_next;
                is_write_reg      <= is_write_next;
                cur_addr_reg      <= cur_addr_next;
                bytes_left_reg    <= bytes_left_next;
                bytes_done_reg    <= bytes_done_next;
                attempts_left_reg <= attempts_left_next;
                polls_left_reg    <= polls_left_next;
            end
            else if (out_beat)
            begin
                res_idx_reg <= res_idx_reg + 3'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
        if (process)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_buf_reg[i] <= res_arr[i];
            end
        end
    end

    // Checks
    `SEAS_ASSERT_ALWAYS(a_idx_in_range, res_idx_reg <= res_n_reg && res_n_reg <= 3'd4,
        "result index beyond buffer fill")
    `SEAS_ASSERT_ALWAYS(a_tlast_on_final, !m_axis_tvalid
        || (m_axis_tlast == (res_idx_reg == 3'(res_n_reg - 3'd1))),
        "tlast not on final result beat")
    `SEAS_ASSERT_ALWAYS(a_stall_only_when_busy, s_axis_tready || (in_valid_reg && m_axis_tvalid),
        "input stalled with an empty result buffer")
    `SEAS_ASSERT_NEXT(a_accept_registers, s_axis_tvalid && s_axis_tready, in_valid_reg,
        "accepted beat not held in input register")

endmodule
